/* rtl/sar_pkg.sv */
// Package for the sensor average ranker: field widths, row kinds and item types.
// Used by sensor_average_ranker; no dependencies.
package sar_pkg;

  localparam int unsigned TEMP_BITS  = 7;
  localparam int unsigned COUNT_BITS = 16;
  localparam int unsigned SUM_BITS   = TEMP_BITS + COUNT_BITS;
  localparam int unsigned ID_BITS    = 5;
  localparam int unsigned TOTAL_BITS = 6;

  localparam logic [TEMP_BITS-1:0] THRESH_RESET = TEMP_BITS'(100);

  localparam logic ROW_ALARM  = 1'b0;
  localparam logic ROW_REPORT = 1'b1;

  typedef struct packed {
    logic [ID_BITS-1:0]   sensor_id;
    logic [TEMP_BITS-1:0] temperature;
    logic                 end_of_session;
  } in_item_t;

  typedef struct packed {
    logic                  row_kind;
    logic [ID_BITS-1:0]    channel_id;
    logic [SUM_BITS-1:0]   channel_sum;
    logic [COUNT_BITS-1:0] channel_count;
    logic [TEMP_BITS-1:0]  channel_average;
    logic                  channel_alarm;
    logic [TOTAL_BITS-1:0] alarm_total;
    logic                  last_row;
  } out_item_t;

endpackage

/* rtl/sar_ram.sv */
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
module sar_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/sensor_average_ranker.sv */
// Sensor average ranker top level: per-channel sum/count/alarm store, averaging and report.
// Depends on sar_pkg and sar_ram.
//
// A sample is accepted, then its channel entry in the channel RAM is read, modified and
// written back; a sample that raises the alarm then runs through the divider and hands
// its event to the output register. An end-of-session item averages every channel
// through the shared restoring divider, then for each reported row scans the average
// RAM and outputs the row, then runs a clearing pass. The same clearing pass runs
// after reset before the first item is taken. The threshold register can be written
// at any time.
module sensor_average_ranker #(
  parameter int unsigned CHANNELS = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [sar_pkg::TEMP_BITS-1:0]  cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  sar_pkg::in_item_t              in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output sar_pkg::out_item_t             out_data_o
);

  localparam int unsigned T   = sar_pkg::TEMP_BITS;
  localparam int unsigned C   = sar_pkg::COUNT_BITS;
  localparam int unsigned S   = sar_pkg::SUM_BITS;
  localparam int unsigned CW  = $clog2(CHANNELS);
  localparam int unsigned CW1 = $clog2(CHANNELS + 1);
  localparam int unsigned MW  = S + C + 1;
  localparam int unsigned AW  = T + 1;
  localparam int unsigned DCW = $clog2(T);
  localparam logic [CW1-1:0] LAST_K = CW1'(CHANNELS - 1);
  localparam logic [CW1-1:0] NUM_K  = CW1'(CHANNELS);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_SUPD  = 4'd2;
  localparam logic [3:0] S_SDIV  = 4'd3;
  localparam logic [3:0] S_SEMIT = 4'd4;
  localparam logic [3:0] S_ARD   = 4'd5;
  localparam logic [3:0] S_ALD   = 4'd6;
  localparam logic [3:0] S_ADIV  = 4'd7;
  localparam logic [3:0] S_SCAN  = 4'd8;
  localparam logic [3:0] S_ROUT  = 4'd9;

  logic [3:0]          state_q;
  logic [CW1-1:0]      k_q;
  logic [T-1:0]        thr_q;
  logic [CW-1:0]       cur_id_q;
  logic [T-1:0]        cur_t_q;
  logic [S-1:0]        sum_q;
  logic [C-1:0]        cnt_q;
  logic [S-1:0]        rem_q;
  logic [S-1:0]        dsr_q;
  logic [T-1:0]        quo_q;
  logic [DCW-1:0]      dcnt_q;
  logic [CW1-1:0]      alarm_cnt_q;
  logic [CW1-1:0]      filled_q;
  logic [CW1-1:0]      rows_q;
  logic [CHANNELS-1:0] done_q;
  logic                sv_q;
  logic [CW-1:0]       sidx_q;
  logic                found_q;
  logic [CW-1:0]       best_q;
  logic [T-1:0]        best_avg_q;
  logic                out_valid_q;
  sar_pkg::out_item_t  out_q;
  sar_pkg::out_item_t  out_d;

  logic          main_we, main_re;
  logic [CW-1:0] main_waddr, main_raddr;
  logic [MW-1:0] main_wdata, main_rdata;
  logic          avg_we, avg_re;
  logic [CW-1:0] avg_waddr, avg_raddr;
  logic [AW-1:0] avg_wdata, avg_rdata;

  logic          in_acc, id_ok, free, out_load, full, new_flag, ge, last;
  logic [S-1:0]  rd_sum, new_sum;
  logic [C-1:0]  rd_cnt, new_cnt;
  logic          rd_alarm;
  logic [T-1:0]  quo_nx;

  sar_ram #(.WIDTH(MW), .DEPTH(CHANNELS)) u_main_ram (
    .clk_i   (clk_i),
    .we_i    (main_we),
    .waddr_i (main_waddr),
    .wdata_i (main_wdata),
    .re_i    (main_re),
    .raddr_i (main_raddr),
    .rdata_o (main_rdata)
  );

  sar_ram #(.WIDTH(AW), .DEPTH(CHANNELS)) u_avg_ram (
    .clk_i   (clk_i),
    .we_i    (avg_we),
    .waddr_i (avg_waddr),
    .wdata_i (avg_wdata),
    .re_i    (avg_re),
    .raddr_i (avg_raddr),
    .rdata_o (avg_rdata)
  );

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && (state_q == S_IDLE);
  assign id_ok       = (int'(in_data_i.sensor_id) < int'(CHANNELS));
  assign free        = !out_valid_q || !out_stall_i;
  assign out_load    = ((state_q == S_SEMIT) || (state_q == S_ROUT)) && free;

  assign rd_sum   = main_rdata[S-1:0];
  assign rd_cnt   = main_rdata[S +: C];
  assign rd_alarm = main_rdata[MW-1];
  assign new_sum  = rd_sum + S'(cur_t_q);
  assign new_cnt  = rd_cnt + C'(1);
  assign full     = (rd_cnt == {C{1'b1}});
  assign new_flag = (cur_t_q > thr_q);
  assign ge       = (rem_q >= dsr_q);
  assign quo_nx   = {quo_q[T-2:0], ge};
  assign last     = ((rows_q + CW1'(1)) == filled_q);

  always_comb begin
    main_we    = 1'b0;
    main_waddr = '0;
    main_wdata = '0;
    main_re    = 1'b0;
    main_raddr = '0;
    avg_we     = 1'b0;
    avg_waddr  = '0;
    avg_wdata  = '0;
    avg_re     = 1'b0;
    avg_raddr  = '0;
    case (state_q)
      S_CLR: begin
        main_we    = 1'b1;
        main_waddr = k_q[CW-1:0];
      end
      S_IDLE: begin
        if (in_acc && !in_data_i.end_of_session && id_ok) begin
          main_re    = 1'b1;
          main_raddr = CW'(in_data_i.sensor_id);
        end
      end
      S_SUPD: begin
        if (!full) begin
          main_we    = 1'b1;
          main_waddr = cur_id_q;
          main_wdata = {new_flag, new_cnt, new_sum};
        end
      end
      S_ARD: begin
        main_re    = 1'b1;
        main_raddr = k_q[CW-1:0];
      end
      S_ADIV: begin
        if (dcnt_q == '0) begin
          avg_we    = 1'b1;
          avg_waddr = k_q[CW-1:0];
          avg_wdata = (cnt_q != '0) ? {1'b1, quo_nx} : '0;
        end
      end
      S_SCAN: begin
        if (k_q < NUM_K) begin
          avg_re    = 1'b1;
          avg_raddr = k_q[CW-1:0];
        end else if (!sv_q && found_q) begin
          main_re    = 1'b1;
          main_raddr = best_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_d = '0;
    if (state_q == S_SEMIT) begin
      out_d.row_kind        = sar_pkg::ROW_ALARM;
      out_d.channel_id      = sar_pkg::ID_BITS'(cur_id_q);
      out_d.channel_sum     = sum_q;
      out_d.channel_count   = cnt_q;
      out_d.channel_average = quo_q;
      out_d.channel_alarm   = 1'b1;
      out_d.alarm_total     = sar_pkg::TOTAL_BITS'(alarm_cnt_q);
      out_d.last_row        = 1'b0;
    end else begin
      out_d.row_kind        = sar_pkg::ROW_REPORT;
      out_d.channel_id      = sar_pkg::ID_BITS'(best_q);
      out_d.channel_sum     = rd_sum;
      out_d.channel_count   = rd_cnt;
      out_d.channel_average = best_avg_q;
      out_d.channel_alarm   = rd_alarm;
      out_d.alarm_total     = sar_pkg::TOTAL_BITS'(alarm_cnt_q);
      out_d.last_row        = last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= sar_pkg::THRESH_RESET;
    end else if (cfg_valid_i) begin
      thr_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      k_q         <= '0;
      alarm_cnt_q <= '0;
      filled_q    <= '0;
      rows_q      <= '0;
      done_q      <= '0;
      sv_q        <= 1'b0;
      found_q     <= 1'b0;
    end else begin
      case (state_q)
        S_CLR: begin
          k_q <= k_q + CW1'(1);
          if (k_q == LAST_K) begin
            alarm_cnt_q <= '0;
            filled_q    <= '0;
            rows_q      <= '0;
            state_q     <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            if (in_data_i.end_of_session) begin
              k_q     <= '0;
              done_q  <= '0;
              rows_q  <= '0;
              state_q <= S_ARD;
            end else if (id_ok) begin
              cur_id_q <= CW'(in_data_i.sensor_id);
              cur_t_q  <= in_data_i.temperature;
              state_q  <= S_SUPD;
            end
          end
        end
        S_SUPD: begin
          if (full) begin
            state_q <= S_IDLE;
          end else begin
            sum_q <= new_sum;
            cnt_q <= new_cnt;
            if (rd_cnt == '0) begin
              filled_q <= filled_q + CW1'(1);
            end
            if (new_flag && !rd_alarm) begin
              alarm_cnt_q <= alarm_cnt_q + CW1'(1);
            end else if (!new_flag && rd_alarm) begin
              alarm_cnt_q <= alarm_cnt_q - CW1'(1);
            end
            if (new_flag) begin
              rem_q   <= new_sum;
              dsr_q   <= S'(new_cnt) << (T - 1);
              quo_q   <= '0;
              dcnt_q  <= DCW'(T - 1);
              state_q <= S_SDIV;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end
        S_SDIV: begin
          if (ge) begin
            rem_q <= rem_q - dsr_q;
          end
          dsr_q  <= dsr_q >> 1;
          quo_q  <= quo_nx;
          dcnt_q <= dcnt_q - DCW'(1);
          if (dcnt_q == '0) begin
            state_q <= S_SEMIT;
          end
        end
        S_SEMIT: begin
          if (free) begin
            state_q <= S_IDLE;
          end
        end
        S_ARD: begin
          state_q <= S_ALD;
        end
        S_ALD: begin
          cnt_q   <= rd_cnt;
          rem_q   <= rd_sum;
          dsr_q   <= S'(rd_cnt) << (T - 1);
          quo_q   <= '0;
          dcnt_q  <= DCW'(T - 1);
          state_q <= S_ADIV;
        end
        S_ADIV: begin
          if (ge) begin
            rem_q <= rem_q - dsr_q;
          end
          dsr_q  <= dsr_q >> 1;
          quo_q  <= quo_nx;
          dcnt_q <= dcnt_q - DCW'(1);
          if (dcnt_q == '0) begin
            if (k_q == LAST_K) begin
              k_q     <= '0;
              sv_q    <= 1'b0;
              found_q <= 1'b0;
              state_q <= S_SCAN;
            end else begin
              k_q     <= k_q + CW1'(1);
              state_q <= S_ARD;
            end
          end
        end
        S_SCAN: begin
          if (k_q < NUM_K) begin
            k_q    <= k_q + CW1'(1);
            sv_q   <= 1'b1;
            sidx_q <= k_q[CW-1:0];
          end else begin
            sv_q <= 1'b0;
          end
          if (sv_q && avg_rdata[T] && !done_q[sidx_q] &&
              (!found_q || (avg_rdata[T-1:0] > best_avg_q))) begin
            found_q    <= 1'b1;
            best_q     <= sidx_q;
            best_avg_q <= avg_rdata[T-1:0];
          end
          if ((k_q == NUM_K) && !sv_q) begin
            if (found_q) begin
              state_q <= S_ROUT;
            end else begin
              k_q     <= '0;
              state_q <= S_CLR;
            end
          end
        end
        S_ROUT: begin
          if (free) begin
            done_q[best_q] <= 1'b1;
            rows_q         <= rows_q + CW1'(1);
            k_q            <= '0;
            if (last) begin
              state_q <= S_CLR;
            end else begin
              sv_q    <= 1'b0;
              found_q <= 1'b0;
              state_q <= S_SCAN;
            end
          end
        end
        default: begin
          state_q <= S_CLR;
          k_q     <= '0;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_alarm_le_filled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alarm_cnt_q <= filled_q)
    else $error("alarm count exceeds filled channel count");

  a_rows_le_filled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rows_q <= filled_q)
    else $error("more report rows than filled channels");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_data_i.end_of_session || id_ok)) |=> (state_q != S_IDLE))
    else $error("accepted item did not start work");

  a_report_row_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROUT) |-> (found_q && !done_q[best_q]))
    else $error("report row for a channel already reported");

endmodule

/* tb/sv/sensor_average_ranker_test.sv */
// Self-checking testbench for sensor_average_ranker: per-channel alarm events and ranked reports.
// Scoreboard class predicts rows from accepted samples; depends on sar_pkg and the RTL.
module sensor_average_ranker_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCH = 32;
  localparam int SETTLE = 1600;
  localparam int CYCLE_LIMIT = 3000000;

  class ranker_scoreboard;
    logic [sar_pkg::TEMP_BITS-1:0]  threshold;
    logic [sar_pkg::SUM_BITS-1:0]   sums [NCH];
    logic [sar_pkg::COUNT_BITS-1:0] counts [NCH];
    logic                           flags [NCH];
    sar_pkg::out_item_t             expected_rows [$];
    int                             errors;

    function new();
      threshold = sar_pkg::THRESH_RESET;
      errors = 0;
      clear_session();
    endfunction

    function void clear_session();
      for (int k = 0; k < NCH; k++) begin
        sums[k] = '0;
        counts[k] = '0;
        flags[k] = 1'b0;
      end
    endfunction

    function int alarm_channels();
      int n;
      n = 0;
      for (int k = 0; k < NCH; k++) n += flags[k];
      return n;
    endfunction

    function logic [sar_pkg::TEMP_BITS-1:0] average_of(int ch);
      if (counts[ch] == 0) return '0;
      return sar_pkg::TEMP_BITS'(sums[ch] / counts[ch]);
    endfunction

    function sar_pkg::out_item_t make_row(logic kind, int ch, int total, logic last);
      sar_pkg::out_item_t r;
      r.row_kind        = kind;
      r.channel_id      = sar_pkg::ID_BITS'(ch);
      r.channel_sum     = sums[ch];
      r.channel_count   = counts[ch];
      r.channel_average = average_of(ch);
      r.channel_alarm   = flags[ch];
      r.alarm_total     = sar_pkg::TOTAL_BITS'(total);
      r.last_row        = last;
      return r;
    endfunction

    function void note_input(sar_pkg::in_item_t it);
      int ch;
      int filled;
      int emitted;
      int total;
      if (!it.end_of_session) begin
        ch = it.sensor_id;
        if (counts[ch] == '1) return;
        sums[ch] = sums[ch] + it.temperature;
        counts[ch] = counts[ch] + 1'b1;
        flags[ch] = it.temperature > threshold;
        if (flags[ch]) begin
          expected_rows.push_back(make_row(sar_pkg::ROW_ALARM, ch, alarm_channels(), 1'b0));
        end
        return;
      end
      filled = 0;
      for (int k = 0; k < NCH; k++) if (counts[k] != 0) filled++;
      total = alarm_channels();
      emitted = 0;
      for (int a = (1 << sar_pkg::TEMP_BITS) - 1; a >= 0; a--) begin
        for (int k = 0; k < NCH; k++) begin
          if (counts[k] != 0 && average_of(k) == a) begin
            emitted++;
            expected_rows.push_back(make_row(sar_pkg::ROW_REPORT, k, total, emitted == filled));
          end
        end
      end
      clear_session();
    endfunction

    function void check(sar_pkg::out_item_t got);
      sar_pkg::out_item_t exp;
      if (expected_rows.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected row %p", got);
        return;
      end
      exp = expected_rows.pop_front();
      if (got.row_kind !== exp.row_kind || got.channel_id !== exp.channel_id ||
          got.channel_sum !== exp.channel_sum || got.channel_count !== exp.channel_count ||
          got.channel_average !== exp.channel_average ||
          got.channel_alarm !== exp.channel_alarm || got.alarm_total !== exp.alarm_total ||
          got.last_row !== exp.last_row) begin
        errors++;
        if (errors <= 10) $display("row mismatch: expected %p actual %p", exp, got);
      end
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [sar_pkg::TEMP_BITS-1:0] cfg_data_i;
  logic                          in_valid_i;
  logic                          in_stall_o;
  sar_pkg::in_item_t             in_data_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  sar_pkg::out_item_t            out_data_o;

  ranker_scoreboard board;
  bit  sender_gaps;
  bit  receiver_stalls;
  int  cycles;

  sensor_average_ranker dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) board.check(out_data_o);
  end

  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (receiver_stalls && $urandom_range(0, 9) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic send_item(sar_pkg::in_item_t it);
    if (!in_valid_i || (sender_gaps && $urandom_range(0, 7) == 0)) begin
      if (in_valid_i) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end
      in_valid_i <= 1'b1;
    end
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    board.note_input(it);
  endtask

  task automatic send_sample(int ch, int temp);
    sar_pkg::in_item_t it;
    it.sensor_id = sar_pkg::ID_BITS'(ch);
    it.temperature = sar_pkg::TEMP_BITS'(temp);
    it.end_of_session = 1'b0;
    send_item(it);
  endtask

  task automatic end_session();
    sar_pkg::in_item_t it;
    it.sensor_id = sar_pkg::ID_BITS'($urandom_range(0, 31));
    it.temperature = sar_pkg::TEMP_BITS'($urandom_range(0, 127));
    it.end_of_session = 1'b1;
    send_item(it);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.expected_rows.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_threshold(int value);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= sar_pkg::TEMP_BITS'(value);
    do @(posedge clk_i); while (!cfg_ready_o);
    board.threshold = sar_pkg::TEMP_BITS'(value);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int left;
    int run;
    board = new();
    sender_gaps = 1'b1;
    receiver_stalls = 1'b1;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_sample(0, 0);
    send_sample(31, 127);
    send_sample(31, 101);
    send_sample(31, 100);
    send_sample(7, 127);
    send_sample(3, 50);
    send_sample(4, 50);
    send_sample(21, 101);
    send_sample(10, 85);
    end_session();
    end_session();
    wait_drained();
    write_threshold(127);
    send_sample(12, 127);
    send_sample(12, 64);
    end_session();
    wait_drained();
    write_threshold(0);
    send_sample(17, 1);
    send_sample(17, 0);
    send_sample(1, 1);
    end_session();
    wait_drained();

    left = 360;
    while (left > 0) begin
      case ($urandom_range(0, 4))
        0: write_threshold(0);
        1: write_threshold(127);
        2: write_threshold($urandom_range(60, 110));
        default: ;
      endcase
      run = $urandom_range(1, 40);
      for (int k = 0; k < run && left > 0; k++) begin
        if (left < 60) begin
          sender_gaps = 1'b0;
          receiver_stalls = 1'b0;
        end
        if ($urandom_range(0, 1)) send_sample($urandom_range(0, 5), $urandom_range(0, 127));
        else send_sample($urandom_range(0, 31), $urandom_range(0, 127));
        left--;
      end
      end_session();
      left--;
      wait_drained();
    end

    if (board.errors == 0 && board.expected_rows.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
